FILE: rtl/set_assoc_lru_cache_tag_lookup_assert.svh
// assertion macros for the cache tag lookup
`ifndef SET_ASSOC_LRU_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAG_LOOKUP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SALC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/salc_pkg.sv
// shared types and constants for the cache tag lookup
package salc_pkg;

    localparam int ADDR_W     = 13;
    localparam int TAG_W      = 13;
    localparam int STAMP_W    = 32;
    localparam int DIV_W      = 14;
    localparam int BS_W       = 14;
    localparam int ROWS_W     = 9;
    localparam int WAYS_W     = 4;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int SET_OUT_W  = 8;
    localparam int WAY_OUT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } way_entry_t;

endpackage

FILE: rtl/salc_ram.sv
// generic single write port, single read port ram with registered read
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/set_assoc_lru_cache_tag_lookup.sv
// set associative cache tag lookup with lru replacement
//
// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_index, cfg_data
// in       in   in_valid, in_ready   address
// out      out  out_valid, out_ready hit, set_index, way_used
//
// a word is taken only in the idle state, and no new word is taken until its
// result is registered: a 13-step shared restoring divider runs twice
// (block number, then set and tag), the set row is read, the ways are walked
// in turn, the row is written back, and the block returns to idle for the next word.
// after reset a clearing pass zeroes the row ram.
// the next word is taken as soon as the result is registered; a stalled
// output only holds the write-back of the following word.
`include "set_assoc_lru_cache_tag_lookup_assert.svh"

module set_assoc_lru_cache_tag_lookup #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [salc_pkg::ADDR_W-1:0]       address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [salc_pkg::SET_OUT_W-1:0]    set_index,
    output logic [salc_pkg::WAY_OUT_W-1:0]    way_used
);
    import salc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int NWC_W  = (NW_W > WAYS_W) ? NW_W : WAYS_W;
    localparam int ROW_W  = MAX_WAYS * $bits(way_entry_t);
    localparam int CNT_W  = $clog2(ADDR_W);

    localparam logic [DIV_W-1:0] SETS_CAP = DIV_W'(MAX_SETS);
    localparam logic [NWC_W-1:0] WAYS_CAP = NWC_W'(MAX_WAYS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ADDR_W - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WALK,
        ST_WRITE
    } state_t;

    // configuration registers
    logic [BS_W-1:0]   block_size_reg;
    logic [ROWS_W-1:0] row_count_reg;
    logic [WAYS_W-1:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BS_W'(1);
            row_count_reg  <= ROWS_W'(1);
            ways_reg       <= WAYS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE: block_size_reg <= cfg_data[BS_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[ROWS_W-1:0];
                REG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective settings: zero acts as one, row and way counts clamp to their limits
    logic [DIV_W-1:0] bs_eff;
    logic [DIV_W-1:0] rows_nz;
    logic [DIV_W-1:0] rows_eff;
    logic [NWC_W-1:0] ways_nz;
    logic [NW_W-1:0]  nw;
    logic [WAY_W-1:0] last_way;

    assign bs_eff   = (block_size_reg == '0) ? DIV_W'(1) : block_size_reg;
    assign rows_nz  = (row_count_reg == '0) ? DIV_W'(1) : DIV_W'(row_count_reg);
    assign rows_eff = (rows_nz > SETS_CAP) ? SETS_CAP : rows_nz;
    assign ways_nz  = (ways_reg == '0) ? NWC_W'(1) : NWC_W'(ways_reg);
    assign nw       = (ways_nz > WAYS_CAP) ? NW_W'(WAYS_CAP) : NW_W'(ways_nz);
    assign last_way = WAY_W'(nw - NW_W'(1));

    state_t              state_reg, state_next;
    logic [SET_W-1:0]    clr_reg, clr_next;
    logic [STAMP_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [CNT_W-1:0]    bit_reg, bit_next;
    logic                phase_reg, phase_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [WAY_W-1:0]    walk_reg, walk_next;
    logic                hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic                inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]    inv_way_reg, inv_way_next;
    logic [STAMP_W-1:0]  min_stamp_reg, min_stamp_next;
    logic [WAY_W-1:0]    min_way_reg, min_way_next;
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [SET_OUT_W-1:0] set_out_reg, set_out_next;
    logic [WAY_OUT_W-1:0] way_out_reg, way_out_next;

    // row ram: one row per set, all ways side by side
    logic                        ram_we;
    logic [SET_W-1:0]            ram_waddr;
    logic [ROW_W-1:0]            ram_wdata;
    logic                        ram_re;
    logic [ROW_W-1:0]            ram_rdata;
    way_entry_t [MAX_WAYS-1:0]   row_rd;
    way_entry_t [MAX_WAYS-1:0]   row_new;
    way_entry_t                  cur_entry;
    logic [WAY_W-1:0]            pick;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (set_reg),
        .rdata (ram_rdata)
    );

    assign row_rd    = ram_rdata;
    assign cur_entry = row_rd[walk_reg];
    assign pick      = hit_found_reg ? hit_way_reg :
                       (inv_found_reg ? inv_way_reg : min_way_reg);

    always_comb
    begin
        row_new = row_rd;
        row_new[pick].stamp = count_reg;
        if (!hit_found_reg)
        begin
            row_new[pick].valid = 1'b1;
            row_new[pick].tag   = tag_reg;
        end
    end

    // shared divider step, dividend shifts out of the quotient register
    logic [DIV_W:0]   trial;
    logic             trial_ge;
    logic [DIV_W-1:0] rem_step;
    logic [ADDR_W-1:0] quo_step;

    assign trial    = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};
    assign rem_step = trial_ge ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    assign quo_step = {quo_reg[ADDR_W-2:0], trial_ge};

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        tag_next       = tag_reg;
        set_next       = set_reg;
        walk_next      = walk_reg;
        hit_found_next = hit_found_reg;
        hit_way_next   = hit_way_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        min_stamp_next = min_stamp_reg;
        min_way_next   = min_way_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        set_out_next   = set_out_reg;
        way_out_next   = way_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = set_reg;
        ram_wdata      = row_new;
        ram_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = SET_W'(clr_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    quo_next   = address;
                    rem_next   = '0;
                    div_next   = bs_eff;
                    bit_next   = '0;
                    phase_next = 1'b0;
                    if (count_reg != '1)
                    begin
                        count_next = STAMP_W'(count_reg + 1'b1);
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                bit_next = CNT_W'(bit_reg + 1'b1);
                if (bit_reg == LAST_BIT)
                begin
                    bit_next = '0;
                    if (!phase_reg)
                    begin
                        // block number becomes the dividend of the set split
                        rem_next   = '0;
                        div_next   = rows_eff;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        tag_next   = quo_step;
                        set_next   = rem_step[SET_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re         = 1'b1;
                walk_next      = '0;
                hit_found_next = 1'b0;
                inv_found_next = 1'b0;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                if (!hit_found_reg && cur_entry.valid && cur_entry.tag == tag_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_way_next   = walk_reg;
                end
                if (!inv_found_reg && !cur_entry.valid)
                begin
                    inv_found_next = 1'b1;
                    inv_way_next   = walk_reg;
                end
                // strict less keeps the lowest way on equal stamps
                if (walk_reg == '0 || cur_entry.stamp < min_stamp_reg)
                begin
                    min_stamp_next = cur_entry.stamp;
                    min_way_next   = walk_reg;
                end
                if (walk_reg == last_way)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    walk_next = WAY_W'(walk_reg + 1'b1);
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    hit_next       = hit_found_reg;
                    set_out_next   = SET_OUT_W'(set_reg);
                    way_out_next   = WAY_OUT_W'(pick);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            bit_reg       <= '0;
            phase_reg     <= 1'b0;
            tag_reg       <= '0;
            set_reg       <= '0;
            walk_reg      <= '0;
            hit_found_reg <= 1'b0;
            hit_way_reg   <= '0;
            inv_found_reg <= 1'b0;
            inv_way_reg   <= '0;
            min_stamp_reg <= '0;
            min_way_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            set_out_reg   <= '0;
            way_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            div_reg       <= div_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            set_reg       <= set_next;
            walk_reg      <= walk_next;
            hit_found_reg <= hit_found_next;
            hit_way_reg   <= hit_way_next;
            inv_found_reg <= inv_found_next;
            inv_way_reg   <= inv_way_next;
            min_stamp_reg <= min_stamp_next;
            min_way_reg   <= min_way_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            set_out_reg   <= set_out_next;
            way_out_reg   <= way_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign set_index = set_out_reg;
    assign way_used  = way_out_reg;

    `SALC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "word accepted but block still ready")
    `SALC_ASSERT_IMPL(a_walk_in_range, clk, rst_n, state_reg == ST_WALK, NW_W'(walk_reg) < nw, "way walk beyond ways in use")
    `SALC_ASSERT_NEXT(a_count_no_wrap, clk, rst_n, 1'b1, count_reg >= $past(count_reg), "access count went backward")
    `SALC_ASSERT_IMPL(a_hit_way_holds_tag, clk, rst_n, state_reg == ST_WRITE && hit_found_reg, row_rd[pick].valid && row_rd[pick].tag == tag_reg, "hit way does not hold the tag")

endmodule

FILE: bench/set_assoc_lru_cache_tag_lookup_test.sv
// testbench for the set associative cache tag lookup with lru replacement
`timescale 1ns / 100ps

module set_assoc_lru_cache_tag_lookup_test;
    import salc_pkg::*;

    localparam int SETS_MAX     = 256;
    localparam int WAYS_MAX     = 8;
    localparam int LINES        = SETS_MAX * WAYS_MAX;
    localparam int ADDR_SPAN    = 8192;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_WORDS  = 104;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_RECV_HEAVY,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_index;
        logic [WAY_OUT_W-1:0] way_used;
    } lookup_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [ADDR_W-1:0]     address;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [SET_OUT_W-1:0]  set_index;
    logic [WAY_OUT_W-1:0]  way_used;

    int send_idle_pct;
    int recv_idle_pct;

    // register settings of the random phases, two of them drawn at run time
    logic [CFG_DATA_W-1:0] plan_bs [NUM_PHASES] =
        '{14'd1, 14'd4, 14'h3fff, 14'd0, 14'd3, 14'd1, 14'd2, 14'd64, 14'd1, 14'd0,
          14'd1, 14'd0};
    logic [CFG_DATA_W-1:0] plan_rows [NUM_PHASES] =
        '{14'd1, 14'd16, 14'h3fff, 14'd0, 14'd7, 14'd256, 14'd5, 14'd32, 14'd257,
          14'd0, 14'd200, 14'd0};
    logic [CFG_DATA_W-1:0] plan_ways [NUM_PHASES] =
        '{14'd1, 14'd4, 14'h3fff, 14'd0, 14'd3, 14'd8, 14'd8, 14'd2, 14'd12, 14'd0,
          14'd5, 14'd0};

    class lru_lookup_board;
        logic [BS_W-1:0]    block_size;
        logic [ROWS_W-1:0]  row_count;
        logic [WAYS_W-1:0]  way_count;
        bit                 line_valid [LINES];
        logic [TAG_W-1:0]   line_tag   [LINES];
        logic [STAMP_W-1:0] line_stamp [LINES];
        logic [STAMP_W-1:0] accesses;
        lookup_t            expected_lookups [$];
        int                 mismatches;
        int                 checked;
        int                 accepted;
        int                 hits;

        function void clear();
            for (int i = 0; i < LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            accesses   = '0;
            block_size = BS_W'(1);
            row_count  = ROWS_W'(1);
            way_count  = WAYS_W'(1);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BLOCK_SIZE: block_size = data[BS_W-1:0];
                REG_ROW_COUNT:  row_count  = data[ROWS_W-1:0];
                REG_WAYS:       way_count  = data[WAYS_W-1:0];
                default:        ;
            endcase
        endfunction

        function int unsigned eff_block();
            return (block_size == 0) ? 1 : block_size;
        endfunction

        function int unsigned eff_rows();
            if (row_count == 0)
                return 1;
            return (row_count > SETS_MAX) ? SETS_MAX : row_count;
        endfunction

        function int unsigned eff_ways();
            if (way_count == 0)
                return 1;
            return (way_count > WAYS_MAX) ? WAYS_MAX : way_count;
        endfunction

        function void note_access(logic [ADDR_W-1:0] addr);
            int unsigned nw, blk, set_no, tg, base, pick, w;
            bit          found;
            lookup_t     e;
            nw = eff_ways();
            if (accesses != '1)
                accesses++;
            blk    = addr / eff_block();
            set_no = blk % eff_rows();
            tg     = (blk / eff_rows()) & 13'h1fff;
            base   = set_no * WAYS_MAX;
            pick   = nw;
            found  = 1'b0;
            for (w = 0; w < nw; w++)
            begin
                if (!found && line_valid[base + w] && line_tag[base + w] == tg)
                begin
                    pick  = w;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                for (w = 0; w < nw; w++)
                begin
                    if (pick == nw && !line_valid[base + w])
                        pick = w;
                end
                // set full: oldest stamp goes, lowest way on ties
                if (pick == nw)
                begin
                    pick = 0;
                    for (w = 1; w < nw; w++)
                    begin
                        if (line_stamp[base + w] < line_stamp[base + pick])
                            pick = w;
                    end
                end
                line_valid[base + pick] = 1'b1;
                line_tag[base + pick]   = TAG_W'(tg);
            end
            line_stamp[base + pick] = accesses;
            e.hit       = found;
            e.set_index = set_no[SET_OUT_W-1:0];
            e.way_used  = pick[WAY_OUT_W-1:0];
            expected_lookups = {expected_lookups, e};
            accepted++;
            if (found)
                hits++;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic h, logic [SET_OUT_W-1:0] s, logic [WAY_OUT_W-1:0] w);
            lookup_t e;
            if (expected_lookups.size() == 0)
            begin
                report($sformatf("unexpected word: hit %0b set %0d way %0d", h, s, w));
                return;
            end
            e = expected_lookups.pop_front();
            checked++;
            if (h !== e.hit)
                report($sformatf("result %0d hit %0b, want %0b", checked, h, e.hit));
            if (s !== e.set_index)
                report($sformatf("result %0d set %0d, want %0d", checked, s, e.set_index));
            if (w !== e.way_used)
                report($sformatf("result %0d way %0d, want %0d", checked, w, e.way_used));
        endtask
    endclass

    lru_lookup_board lookups;

    set_assoc_lru_cache_tag_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .address   (address),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .set_index (set_index),
        .way_used  (way_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: ready chosen at the falling edge, words taken at the rising edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                lookups.check_result(hit, set_index, way_used);
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_RECV_HEAVY: begin send_idle_pct = 31; recv_idle_pct = 62; end
            IDLE_SEND_HEAVY: begin send_idle_pct = 62; recv_idle_pct = 31; end
            default:         begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        lookups.write_reg(idx, val);
    endtask

    task automatic send_word(input logic [ADDR_W-1:0] a);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        address  = a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lookups.note_access(a);
    endtask

    // registers only change once every outstanding word is back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (lookups.expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int p);
        int unsigned       blk, eb, er, ew;
        logic [ADDR_W-1:0] a;
        wait_idle();
        set_idling(idle_mode_t'(p * 3 / NUM_PHASES));
        write_reg(REG_BLOCK_SIZE, plan_bs[p]);
        write_reg(REG_ROW_COUNT, plan_rows[p]);
        write_reg(REG_WAYS, plan_ways[p]);
        eb = lookups.eff_block();
        er = lookups.eff_rows();
        ew = lookups.eff_ways();
        repeat (PHASE_WORDS)
        begin
            // mostly a working set a bit over capacity so hits and evictions mix
            if ($urandom_range(0, 99) < 75)
            begin
                blk = $urandom_range(0, er * (ew + 2) - 1);
                a   = ADDR_W'((blk * eb + $urandom_range(0, eb - 1)) % ADDR_SPAN);
            end
            else
                a = ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
            send_word(a);
        end
    endtask

    initial
    begin
        lookups = new;
        lookups.clear();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_BLOCK_SIZE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        address   = '0;
        set_idling(IDLE_RECV_HEAVY);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one set, one way
        send_word(13'd0);
        send_word(13'd0);
        send_word(13'h1fff);
        send_word(13'd0);

        // zero in every register acts as one
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 14'd0);
        write_reg(REG_ROW_COUNT, 14'd0);
        write_reg(REG_WAYS, 14'd0);
        send_word(13'd1);
        send_word(13'd1);

        // widest block size folds every address into block zero
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 14'h3fff);
        send_word(13'h1fff);
        send_word(13'd0);

        // oversized row and way counts clamp, then fill one set past its ways
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 14'd1);
        write_reg(REG_ROW_COUNT, 14'h3fff);
        write_reg(REG_WAYS, 14'd15);
        for (int k = 0; k <= WAYS_MAX; k++)
            send_word(ADDR_W'(5 + 256 * k));
        send_word(ADDR_W'(5 + 256 * 3));

        // fewer ways keeps entries, upper ways drop out of search
        wait_idle();
        write_reg(REG_UNUSED, 14'h3fff);
        write_reg(REG_WAYS, 14'h3ff2);
        send_word(ADDR_W'(5 + 256 * 1));
        send_word(ADDR_W'(5 + 256 * 7));

        plan_bs[9]    = CFG_DATA_W'($urandom_range(1, 32));
        plan_rows[9]  = CFG_DATA_W'($urandom_range(1, 300));
        plan_ways[9]  = CFG_DATA_W'($urandom_range(0, 15));
        plan_bs[11]   = CFG_DATA_W'($urandom_range(0, 16383));
        plan_rows[11] = CFG_DATA_W'($urandom_range(0, 16383));
        plan_ways[11] = CFG_DATA_W'($urandom_range(0, 16383));
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p);
        wait_idle();

        $display("ran %0d lookups (%0d hits) across %0d register settings with mixed stalls",
                 lookups.accepted, lookups.hits, NUM_PHASES + 5);
        $display("checked %0d results, %0d mismatches", lookups.checked, lookups.mismatches);
        if (lookups.mismatches == 0 && lookups.expected_lookups.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
